// ===== rtl/row_line_center_finder_defines.svh =====
// assertion macros for the row line center finder
`ifndef ROW_LINE_CENTER_FINDER_DEFINES_SVH
`define ROW_LINE_CENTER_FINDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RLCF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define RLCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define RLCF_ASSERT_SAME(label, clk, rst, ante, cons)
`define RLCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/rlcf_pkg.sv =====
package rlcf_pkg;

  localparam int COL_W = 10;
  localparam int ADDR_W = 4;
  localparam int FRAME_COLS_DEFAULT = 160;

  localparam logic [COL_W-1:0] MIN_WIDTH_RESET = 10'd10;
  localparam logic [COL_W-1:0] MAX_WIDTH_RESET = 10'd60;
  localparam logic [COL_W-1:0] MERGE_GAP_RESET = 10'd5;

  typedef enum logic [1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_DISCARD = 2'd1,
    STATUS_HELD    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_HOLD_WHEN_NONE = 2'd0,
    REG_MIN_WIDTH      = 2'd1,
    REG_MAX_WIDTH      = 2'd2,
    REG_MERGE_GAP      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             hold_when_none;
    logic [COL_W-1:0] min_width;
    logic [COL_W-1:0] max_width;
    logic [COL_W-1:0] merge_gap;
  } cfg_t;

  typedef struct packed {
    logic             pixel_set;
    logic [COL_W-1:0] column;
    logic             row_end;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] center;
    status_t          status;
  } result_t;

  // confirmed run end bookkeeping
  typedef struct packed {
    logic [COL_W-1:0] last_edge;
    logic             pending_valid;
    logic             pair_found;
    logic [COL_W-1:0] row_center;
  } run_t;

  function automatic logic [COL_W-1:0] spacing(logic [COL_W-1:0] a, logic [COL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic qualifies(logic [COL_W-1:0] d, cfg_t c);
    return (d > c.min_width) && (d < c.max_width);
  endfunction

  function automatic logic [COL_W-1:0] mean(logic [COL_W-1:0] a, logic [COL_W-1:0] b);
    logic [COL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COL_W:1];
  endfunction

  function automatic run_t take_run_end(run_t st, logic [COL_W-1:0] e, cfg_t c);
    run_t r;
    r = st;
    if (!st.pair_found && st.pending_valid && qualifies(spacing(e, st.last_edge), c)) begin
      r.pair_found = 1'b1;
      r.row_center = mean(e, st.last_edge);
    end
    r.last_edge = e;
    r.pending_valid = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/rlcf_cfg.sv =====
module rlcf_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rlcf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rlcf_pkg::cfg_t             cfg
);

  logic wr_en;
  rlcf_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = rlcf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_when_none <= 1'b0;
      cfg.min_width <= rlcf_pkg::MIN_WIDTH_RESET;
      cfg.max_width <= rlcf_pkg::MAX_WIDTH_RESET;
      cfg.merge_gap <= rlcf_pkg::MERGE_GAP_RESET;
    end else if (wr_en) begin
      case (idx)
        rlcf_pkg::REG_HOLD_WHEN_NONE: cfg.hold_when_none <= pwdata[0];
        rlcf_pkg::REG_MIN_WIDTH: cfg.min_width <= pwdata[rlcf_pkg::COL_W-1:0];
        rlcf_pkg::REG_MAX_WIDTH: cfg.max_width <= pwdata[rlcf_pkg::COL_W-1:0];
        rlcf_pkg::REG_MERGE_GAP: cfg.merge_gap <= pwdata[rlcf_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rlcf_pkg::REG_HOLD_WHEN_NONE: prdata = {31'd0, cfg.hold_when_none};
      rlcf_pkg::REG_MIN_WIDTH: prdata = {22'd0, cfg.min_width};
      rlcf_pkg::REG_MAX_WIDTH: prdata = {22'd0, cfg.max_width};
      rlcf_pkg::REG_MERGE_GAP: prdata = {22'd0, cfg.merge_gap};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/rlcf_row.sv =====
module rlcf_row #(
  parameter int FRAME_COLS = rlcf_pkg::FRAME_COLS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  rlcf_pkg::cfg_t      cfg,
  input  logic                fire,
  input  rlcf_pkg::pixel_t    pix,
  output rlcf_pkg::result_t   result
);

  localparam logic [rlcf_pkg::COL_W-1:0] HELD_RESET = rlcf_pkg::COL_W'(FRAME_COLS / 2);

  logic [1:0]                  edge_count;
  logic [rlcf_pkg::COL_W-1:0]  pending_end;
  rlcf_pkg::run_t              run;
  logic                        pair2_found;
  logic [rlcf_pkg::COL_W-1:0]  pair2_center;
  logic [rlcf_pkg::COL_W-1:0]  held_center;

  logic [rlcf_pkg::COL_W-1:0]  d1;
  rlcf_pkg::run_t              run_next;
  rlcf_pkg::run_t              run_close;
  logic [1:0]                  edge_count_next;
  logic [rlcf_pkg::COL_W-1:0]  pending_end_next;
  logic                        pair2_found_next;
  logic [rlcf_pkg::COL_W-1:0]  pair2_center_next;
  logic [rlcf_pkg::COL_W-1:0]  held_center_next;

  always_comb begin
    d1 = rlcf_pkg::spacing(pix.column, pending_end);
    run_next = run;
    pair2_found_next = pair2_found;
    pair2_center_next = pair2_center;
    pending_end_next = pending_end;
    edge_count_next = edge_count;
    if (pix.pixel_set) begin
      if (edge_count != 2'd0) begin
        // raw verdict on the first two set pixels
        if (edge_count == 2'd1 && rlcf_pkg::qualifies(d1, cfg)) begin
          pair2_found_next = 1'b1;
          pair2_center_next = rlcf_pkg::mean(pix.column, pending_end);
        end
        // gap wide enough: the pending pixel ends its run
        if (d1 > cfg.merge_gap) begin
          run_next = rlcf_pkg::take_run_end(run, pending_end, cfg);
        end
      end
      pending_end_next = pix.column;
      if (edge_count != 2'd3) begin
        edge_count_next = edge_count + 2'd1;
      end
    end

    // at row end the last pending pixel closes the final run
    run_close = rlcf_pkg::take_run_end(run_next, pending_end_next, cfg);

    result.center = '0;
    result.status = rlcf_pkg::STATUS_DISCARD;
    held_center_next = held_center;
    if (edge_count_next == 2'd2) begin
      if (pair2_found_next) begin
        result.center = pair2_center_next;
        result.status = rlcf_pkg::STATUS_FOUND;
      end
    end else if (edge_count_next == 2'd3) begin
      if (run_close.pair_found) begin
        result.center = run_close.row_center;
        result.status = rlcf_pkg::STATUS_FOUND;
        held_center_next = run_close.row_center;
      end else if (cfg.hold_when_none) begin
        result.center = held_center;
        result.status = rlcf_pkg::STATUS_HELD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      pending_end <= '0;
      run <= '0;
      pair2_found <= 1'b0;
      pair2_center <= '0;
      held_center <= HELD_RESET;
    end else if (fire) begin
      if (pix.row_end) begin
        edge_count <= '0;
        pending_end <= '0;
        run <= '0;
        pair2_found <= 1'b0;
        pair2_center <= '0;
        held_center <= held_center_next;
      end else begin
        edge_count <= edge_count_next;
        pending_end <= pending_end_next;
        run <= run_next;
        pair2_found <= pair2_found_next;
        pair2_center <= pair2_center_next;
      end
    end
  end

endmodule

// ===== rtl/row_line_center_finder.sv =====
// a row-end pixel is registered in the input stage, then its result in the output register
// throughput: one pixel per cycle unless a row-end pixel stalls; one row state step per pixel
// s_tready drops only while a row-end pixel waits on an output register not yet taken
// reset (rst, synchronous, active high) clears row state and both handshake stages,
// restores register defaults and sets the held center to half the frame width
`include "row_line_center_finder_defines.svh"

module row_line_center_finder #(
  parameter int FRAME_COLS = rlcf_pkg::FRAME_COLS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,  // [0] pixel_set, [10:1] column, [15:11] zero
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,  // [9:0] center, [15:10] zero
  output logic [1:0]                  m_tuser,  // [1:0] status
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlcf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rlcf_pkg::cfg_t    cfg;
  rlcf_pkg::pixel_t  in_pix;
  logic              in_valid;
  logic              stall;
  logic              fire;
  rlcf_pkg::result_t result;
  rlcf_pkg::result_t out_res;

  rlcf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlcf_row #(
    .FRAME_COLS (FRAME_COLS)
  ) u_row (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .pix    (in_pix),
    .result (result)
  );

  // a row end can only move on when the output register is free
  assign stall = in_valid && in_pix.row_end && m_tvalid && !m_tready;
  assign fire = in_valid && !stall;
  assign s_tready = !in_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pix.pixel_set <= s_tdata[0];
      in_pix.column <= s_tdata[10:1];
      in_pix.row_end <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && in_pix.row_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_pix.row_end) begin
      out_res <= result;
    end
  end

  assign m_tdata = {6'd0, out_res.center};
  assign m_tuser = out_res.status;

  `RLCF_ASSERT_SAME(a_discard_zero, clk, rst, m_tvalid && m_tuser == rlcf_pkg::STATUS_DISCARD, m_tdata == 16'd0)
  `RLCF_ASSERT_SAME(a_stall_cause, clk, rst, !s_tready, in_valid && in_pix.row_end && m_tvalid && !m_tready)
  `RLCF_ASSERT_NEXT(a_result_from_row_end, clk, rst, !m_tvalid && !(in_valid && in_pix.row_end), !m_tvalid)

endmodule

// ===== tb/sv/row_line_center_finder_tb.sv =====
module row_line_center_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int NUM_PHASES = 6;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [15:0]                 s_tdata = '0;  // [0] pixel_set, [10:1] column, [15:11] zero
  logic                        s_tlast = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [15:0]                 m_tdata;       // [9:0] center, [15:10] zero
  logic [1:0]                  m_tuser;       // [1:0] status
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rlcf_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  row_line_center_finder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // pixel requests waiting to be sent, and centres still owed by the block
  rlcf_pkg::pixel_t  pixel_q[$];
  rlcf_pkg::pixel_t  cur_px;
  rlcf_pkg::result_t center_q[$];

  int send_idle_pct = 25;
  int recv_idle_pct = 67;
  int errors = 0;
  int cycles = 0;
  int pixels_sent = 0;
  int pixels_queued = 0;
  int rows_seen = 0;
  int n_found = 0;
  int n_held = 0;
  int n_discard = 0;
  int phase_items = 0;

  // shadow of the block's registers and row state
  rlcf_pkg::cfg_t shadow_cfg;
  logic [1:0]  set_count;
  logic [9:0]  open_end;
  logic [9:0]  last_end;
  logic        end_valid;
  logic        line_found;
  logic [9:0]  line_center;
  logic        duo_found;
  logic [9:0]  duo_center;
  logic [9:0]  held_center;

  function automatic logic [9:0] col_dist(logic [9:0] a, logic [9:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [9:0] midpoint(logic [9:0] a, logic [9:0] b);
    logic [10:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[10:1];
  endfunction

  function automatic logic in_band(logic [9:0] d);
    return (d > shadow_cfg.min_width) && (d < shadow_cfg.max_width);
  endfunction

  task automatic clear_row_state();
    set_count = '0;
    open_end = '0;
    last_end = '0;
    end_valid = 1'b0;
    line_found = 1'b0;
    line_center = '0;
    duo_found = 1'b0;
    duo_center = '0;
  endtask

  task automatic close_run(logic [9:0] e);
    if (!line_found && end_valid && in_band(col_dist(e, last_end))) begin
      line_found = 1'b1;
      line_center = midpoint(e, last_end);
    end
    last_end = e;
    end_valid = 1'b1;
  endtask

  task automatic track_pixel(rlcf_pkg::pixel_t p);
    logic [9:0] d;
    rlcf_pkg::result_t r;
    if (p.pixel_set) begin
      if (set_count >= 2'd1) begin
        d = col_dist(p.column, open_end);
        // a row of exactly two set pixels is judged on the raw pair
        if (set_count == 2'd1 && in_band(d)) begin
          duo_found = 1'b1;
          duo_center = midpoint(p.column, open_end);
        end
        if (d > shadow_cfg.merge_gap) close_run(open_end);
      end
      open_end = p.column;
      if (set_count < 2'd3) set_count++;
    end
    if (p.row_end) begin
      r.center = '0;
      r.status = rlcf_pkg::STATUS_DISCARD;
      if (set_count == 2'd2) begin
        if (duo_found) begin
          r.center = duo_center;
          r.status = rlcf_pkg::STATUS_FOUND;
        end
      end else if (set_count == 2'd3) begin
        close_run(open_end);
        if (line_found) begin
          held_center = line_center;
          r.center = line_center;
          r.status = rlcf_pkg::STATUS_FOUND;
        end else if (shadow_cfg.hold_when_none) begin
          r.center = held_center;
          r.status = rlcf_pkg::STATUS_HELD;
        end
      end
      center_q = {center_q, r};
      rows_seen++;
      clear_row_state();
    end
  endtask

  task automatic report_mismatch(string what, int exp_v, int got_v);
    if (errors < 50)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_pixel(cur_px);
        pixels_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_px = pixel_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {5'b0, cur_px.column, cur_px.pixel_set};
          s_tlast <= cur_px.row_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (center_q.size() == 0) begin
          report_mismatch("unrequested result, status", -1, int'(m_tuser));
        end else begin
          if (m_tdata[9:0] != center_q[0].center)
            report_mismatch("center", int'(center_q[0].center), int'(m_tdata[9:0]));
          if (m_tuser != center_q[0].status)
            report_mismatch("status", int'(center_q[0].status), int'(m_tuser));
          case (center_q[0].status)
            rlcf_pkg::STATUS_FOUND: n_found++;
            rlcf_pkg::STATUS_HELD:  n_held++;
            default:                n_discard++;
          endcase
          void'(center_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d centres outstanding", cycles, center_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_px(logic set, logic [9:0] col, logic last);
    rlcf_pkg::pixel_t p;
    p.pixel_set = set;
    p.column = col;
    p.row_end = last;
    pixel_q = {pixel_q, p};
    phase_items++;
    pixels_queued++;
  endtask

  // sender holds off until the block has nothing in flight
  task automatic wait_idle();
    while (pixels_sent != pixels_queued || center_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(rlcf_pkg::reg_idx_t idx, logic [9:0] val);
    logic [31:0] keep;
    keep = (idx == rlcf_pkg::REG_HOLD_WHEN_NONE) ? 32'h1 : 32'h3FF;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & ~keep) | ({22'b0, val} & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rlcf_pkg::REG_HOLD_WHEN_NONE: shadow_cfg.hold_when_none = val[0];
      rlcf_pkg::REG_MIN_WIDTH:      shadow_cfg.min_width = val;
      rlcf_pkg::REG_MAX_WIDTH:      shadow_cfg.max_width = val;
      default:                      shadow_cfg.merge_gap = val;
    endcase
  endtask

  function automatic logic [9:0] pick_spacing();
    case ($urandom_range(0, 6))
      0: return shadow_cfg.min_width;
      1: return shadow_cfg.min_width + 10'd1;
      2: return shadow_cfg.max_width - 10'd1;
      3: return shadow_cfg.max_width;
      4: return 10'($urandom_range(shadow_cfg.min_width, shadow_cfg.max_width));
      5: return shadow_cfg.merge_gap + 10'd1;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic add_row();
    int kind;
    int n;
    int runlen;
    logic [9:0] c;
    logic [9:0] cols[$];
    logic closed;
    kind = $urandom_range(0, 9);
    closed = 1'b0;
    if (kind == 0) begin
      // noise: random bits and columns in any order
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        push_px(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)), i == n - 1);
      return;
    end
    if (kind == 1) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) cols = {cols, 10'($urandom_range(0, 1023))};
    end else begin
      c = 10'($urandom_range(0, 1023));
      n = $urandom_range(1, 4);
      for (int r = 0; r < n; r++) begin
        if (r > 0) c = c + pick_spacing();
        runlen = $urandom_range(1, 3);
        for (int k = 0; k < runlen; k++) begin
          if (k > 0) c = c + 10'($urandom_range(0, shadow_cfg.merge_gap));
          cols = {cols, c};
        end
      end
    end
    foreach (cols[i]) begin
      if ($urandom_range(0, 3) == 0) push_px(1'b0, 10'($urandom_range(0, 1023)), 1'b0);
      closed = (i == cols.size() - 1) && ($urandom_range(0, 1) == 1);
      push_px(1'b1, cols[i], closed);
    end
    if (!closed) push_px(1'b0, 10'($urandom_range(0, 1023)), 1'b1);
  endtask

  initial begin : stimulus
    int ph_hold[NUM_PHASES] = '{1, 1, 0, 1, 0, 1};
    int ph_min[NUM_PHASES]  = '{10, 0, 1023, 20, 3, 0};
    int ph_max[NUM_PHASES]  = '{60, 1023, 0, 40, 200, 0};
    int ph_gap[NUM_PHASES]  = '{5, 0, 1023, 3, 8, 0};
    shadow_cfg.hold_when_none = 1'b0;
    shadow_cfg.min_width = rlcf_pkg::MIN_WIDTH_RESET;
    shadow_cfg.max_width = rlcf_pkg::MAX_WIDTH_RESET;
    shadow_cfg.merge_gap = rlcf_pkg::MERGE_GAP_RESET;
    held_center = 10'(rlcf_pkg::FRAME_COLS_DEFAULT / 2);
    clear_row_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed rows with default widths, hold mode on
    write_reg(rlcf_pkg::REG_HOLD_WHEN_NONE, 10'd1);
    push_px(1, 10, 0); push_px(1, 11, 0); push_px(1, 12, 1);     // one run, held reset centre
    push_px(0, 0, 1);                                            // empty row
    push_px(1, 1023, 1);                                         // lone pixel
    push_px(1, 100, 0); push_px(1, 130, 1);                      // raw pair in band
    push_px(1, 200, 0); push_px(1, 210, 1);                      // spacing on the lower bound
    push_px(1, 0, 0); push_px(1, 59, 0); push_px(0, 512, 1);     // row closed by unset pixel
    push_px(1, 1023, 0); push_px(1, 1000, 1);                    // columns going backwards
    push_px(1, 50, 0); push_px(1, 52, 0); push_px(1, 54, 0);
    push_px(1, 80, 0); push_px(0, 3, 0); push_px(1, 82, 1);      // merged runs give a line
    push_px(1, 0, 0); push_px(1, 500, 0); push_px(1, 1000, 1);   // too wide, falls back to held
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        ph_hold[p] = $urandom_range(0, 1);
        ph_min[p] = $urandom_range(0, 40);
        ph_max[p] = $urandom_range(20, 120);
        ph_gap[p] = $urandom_range(0, 12);
      end
      case (p / 2)
        0: begin send_idle_pct = 25; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(rlcf_pkg::REG_HOLD_WHEN_NONE, 10'(ph_hold[p]));
      write_reg(rlcf_pkg::REG_MIN_WIDTH, 10'(ph_min[p]));
      write_reg(rlcf_pkg::REG_MAX_WIDTH, 10'(ph_max[p]));
      write_reg(rlcf_pkg::REG_MERGE_GAP, 10'(ph_gap[p]));
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        add_row();
        // partway through one phase, let everything drain before going on
        if (p == 1 && phase_items >= ITEMS_PER_PHASE / 2 && phase_items < ITEMS_PER_PHASE / 2 + 12)
          wait_idle();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("sent %0d pixels in %0d rows over %0d register settings", pixels_sent, rows_seen,
             NUM_PHASES + 1);
    $display("centres found %0d, held %0d, discarded %0d", n_found, n_held, n_discard);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
